/* rtl/core/wrf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and index helpers for the waypoint ring follower.
// Used by the distance pipeline and the core; depends on nothing else.
package wrf_pkg;

  localparam int MAX_WAYPOINTS  = 16;
  localparam int COORD_BITS     = 24;
  localparam int RAD_W          = COORD_BITS - 1;
  localparam int IDX_W          = $clog2(MAX_WAYPOINTS);
  localparam int IDX_SUM_W      = IDX_W + 1;
  localparam int CNT_W          = $clog2(MAX_WAYPOINTS + 1);
  localparam int ENTRY_W        = 2 * COORD_BITS + RAD_W;
  localparam int DIFF_W         = COORD_BITS + 1;
  localparam int SQ_W           = 2 * COORD_BITS;
  localparam int DSQ_W          = SQ_W + 1;
  localparam int RSQ_W          = 2 * RAD_W;
  localparam int NEAR_MIN_COUNT = 2;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [RAD_W-1:0]      r;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic tag;
  } dist_req_t;

  typedef struct packed {
    logic             valid;
    logic             tag;
    logic [DSQ_W-1:0] dsq;
    logic [RSQ_W-1:0] rsq;
  } dist_res_t;

  // Ring index plus an offset of at most MAX_WAYPOINTS, wrapped once.
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] inc);
    logic [IDX_SUM_W-1:0] sum;
    sum = IDX_SUM_W'(base) + IDX_SUM_W'(inc);
    if (sum >= IDX_SUM_W'(MAX_WAYPOINTS)) begin
      sum = sum - IDX_SUM_W'(MAX_WAYPOINTS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* rtl/core/wrf_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module wrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/wrf_dist.sv */
`timescale 1ns / 1ps
// Three-stage pipeline: squared distance from a waypoint to a position and
// the waypoint's squared radius. Depends on wrf_pkg.
module wrf_dist import wrf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  dist_req_t                    req,
  input  entry_t                       ent,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  output dist_res_t                    res
);

  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic [COORD_BITS-1:0]    mag_x, mag_y;
  logic [RAD_W-1:0]         rad1;
  logic [1:0]               vld1, vld2;
  logic [SQ_W-1:0]          sq_x, sq_y;
  logic [RSQ_W-1:0]         rsq2;

  assign diff_x = DIFF_W'(ent.x) - DIFF_W'(pos_x);
  assign diff_y = DIFF_W'(ent.y) - DIFF_W'(pos_y);

  always_ff @(posedge clk) begin
    mag_x   <= diff_x[DIFF_W-1] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
    mag_y   <= diff_y[DIFF_W-1] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
    rad1    <= ent.r;
    sq_x    <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y    <= SQ_W'(mag_y) * SQ_W'(mag_y);
    rsq2    <= RSQ_W'(rad1) * RSQ_W'(rad1);
    res.dsq <= DSQ_W'(sq_x) + DSQ_W'(sq_y);
    res.rsq <= rsq2;
    if (rst) begin
      vld1      <= '0;
      vld2      <= '0;
      res.valid <= 1'b0;
      res.tag   <= 1'b0;
    end else begin
      vld1      <= {req.valid, req.tag};
      vld2      <= vld1;
      res.valid <= vld2[1];
      res.tag   <= vld2[0];
    end
  end

endmodule

/* rtl/core/waypoint_ring_follower_core.sv */
`timescale 1ns / 1ps
// Waypoint ring follower: circular waypoint list with nearest-next and arrival
// rotation. Depends on wrf_pkg, wrf_ram and wrf_dist.
//
// The block keeps up to MAX_WAYPOINTS waypoints in one waypoint memory and
// returns one transaction on the result channel for every input transaction.
// An append, or a query on an empty list, is answered in idle; the next item is
// accepted in the following cycle once the previous result has been taken.
// A query on a non-empty list needs three reads of the head, next and
// following waypoint through the memory's single read port, the three-stage
// squared-distance pipeline for the head and next waypoint, and up to two
// rotation write-backs through the single write port. The head's coordinates
// are also held in registers, so an append answers without a memory read.
// Output coordinates are zero when the list is empty.
module waypoint_ring_follower_core import wrf_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         operation,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic        [RAD_W-1:0]      radius,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [COORD_BITS-1:0] target_x,
  output logic signed [COORD_BITS-1:0] target_y,
  output logic        [1:0]            status
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_RD_HEAD   = 7'b0000010,
    S_RD_NEXT   = 7'b0000100,
    S_RD_THIRD  = 7'b0001000,
    S_WAIT_DIST = 7'b0010000,
    S_WR_FIRST  = 7'b0100000,
    S_WR_SECOND = 7'b1000000
  } state_t;

  state_t                       state, state_next;
  logic [IDX_W-1:0]             head;
  logic [CNT_W-1:0]             count;
  logic signed [COORD_BITS-1:0] head_x, head_y, pos_x, pos_y;
  entry_t                       ent0, ent1, ent2, rd_ent, final_ent;
  logic [DSQ_W-1:0]             d0, d1, cur_dist;
  logic [RSQ_W-1:0]             r0, r1, cur_rsq;
  status_t                      out_status;

  logic                         item_accept, is_query, is_empty, is_full, out_load;
  logic [IDX_W-1:0]             head_p1, head_p2, tail0, tail1, head_final;
  logic                         near, arrive;
  logic [1:0]                   rot_n;

  logic                         wr_en, rd_en;
  logic [IDX_W-1:0]             wr_addr, rd_addr;
  logic [ENTRY_W-1:0]           wr_data, rd_data;
  dist_req_t                    req;
  dist_res_t                    res;

  assign item_stall  = (state != S_IDLE) || (result_valid && result_stall);
  assign item_accept = item_valid && !item_stall;
  assign is_query    = (operation == OP_QUERY);
  assign is_empty    = (count == '0);
  assign is_full     = (count == CNT_W'(MAX_WAYPOINTS));

  assign head_p1    = idx_add(head, CNT_W'(1));
  assign head_p2    = idx_add(head, CNT_W'(2));
  assign tail0      = idx_add(head, count);
  assign tail1      = idx_add(head_p1, count);
  assign near       = (count > CNT_W'(NEAR_MIN_COUNT)) && (d1 < d0);
  assign cur_dist   = near ? d1 : d0;
  assign cur_rsq    = near ? r1 : r0;
  assign arrive     = cur_dist < DSQ_W'(cur_rsq);
  assign rot_n      = 2'(near) + 2'(arrive);
  assign head_final = idx_add(head, CNT_W'(rot_n));
  assign rd_ent     = entry_t'(rd_data);

  always_comb begin
    priority if (count == CNT_W'(1) || rot_n == 2'd0) begin
      final_ent = ent0;
    end else if (rot_n == 2'd1) begin
      final_ent = ent1;
    end else begin
      final_ent = ent2;
    end
  end

  wrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req = '{valid: (state == S_RD_HEAD) || (state == S_RD_NEXT),
                 tag:   (state == S_RD_NEXT)};

  wrf_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .ent   (rd_ent),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .res   (res)
  );

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = head;
    wr_en      = 1'b0;
    wr_addr    = tail0;
    wr_data    = ent0;
    unique case (state)
      S_IDLE: begin
        rd_en   = 1'b1;
        wr_en   = item_accept && !is_query && !is_full;
        wr_data = {x, y, radius};
        if (item_accept && is_query && !is_empty) begin
          state_next = S_RD_HEAD;
        end
      end
      S_RD_HEAD: begin
        rd_en      = 1'b1;
        rd_addr    = head_p1;
        state_next = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        rd_en      = 1'b1;
        rd_addr    = head_p2;
        state_next = S_RD_THIRD;
      end
      S_RD_THIRD: begin
        state_next = S_WAIT_DIST;
      end
      S_WAIT_DIST: begin
        if (res.valid && res.tag) begin
          state_next = S_WR_FIRST;
        end
      end
      S_WR_FIRST: begin
        wr_en      = (rot_n != 2'd0);
        state_next = S_WR_SECOND;
      end
      S_WR_SECOND: begin
        wr_en      = (rot_n == 2'd2);
        wr_addr    = tail1;
        wr_data    = ent1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_load = (item_accept && !(is_query && !is_empty)) || (state == S_WR_SECOND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (item_accept && !is_query && !is_full) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_WR_SECOND) begin
        head <= head_final;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      pos_x <= x;
      pos_y <= y;
    end
    if (state == S_RD_HEAD) begin
      ent0 <= rd_ent;
    end
    if (state == S_RD_NEXT) begin
      ent1 <= rd_ent;
    end
    if (state == S_RD_THIRD) begin
      ent2 <= rd_ent;
    end
    if (res.valid && !res.tag) begin
      d0 <= res.dsq;
      r0 <= res.rsq;
    end
    if (res.valid && res.tag) begin
      d1 <= res.dsq;
      r1 <= res.rsq;
    end
    if (item_accept && !is_query && is_empty) begin
      head_x <= x;
      head_y <= y;
    end else if (state == S_WR_SECOND) begin
      head_x <= final_ent.x;
      head_y <= final_ent.y;
    end
    if (out_load) begin
      if (state == S_WR_SECOND) begin
        target_x   <= final_ent.x;
        target_y   <= final_ent.y;
        out_status <= STATUS_OK;
      end else if (is_query) begin
        target_x   <= '0;
        target_y   <= '0;
        out_status <= STATUS_EMPTY;
      end else begin
        target_x   <= is_empty ? x : head_x;
        target_y   <= is_empty ? y : head_y;
        out_status <= is_full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

  assign status = out_status;

  assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || !result_stall))
    else $error("result register loaded while a transaction is still pending");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WAYPOINTS))
    else $error("waypoint count exceeds capacity");

  assert property (@(posedge clk) disable iff (rst)
    (item_accept && is_query && !is_empty) |=> item_stall)
    else $error("item accepted while a query is in progress");

  assert property (@(posedge clk) disable iff (rst)
    (item_accept && !is_query) |=> (head == $past(head)))
    else $error("append moved the head index");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR_FIRST) |-> (count > CNT_W'(NEAR_MIN_COUNT) || rot_n != 2'd2))
    else $error("double rotation on a short list");

endmodule

/* tb/sv/tb_waypoint_ring_follower_core.sv */
`timescale 1ns / 1ps
// Testbench for waypoint_ring_follower_core: directed and random append and query
// transactions, checked in order against a behavioral model of the waypoint ring.
// Depends on wrf_pkg and the core RTL.
module tb_waypoint_ring_follower_core;
  import wrf_pkg::*;

  localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
  localparam logic signed [COORD_BITS-1:0] XY_MAX = COORD_MAX[COORD_BITS-1:0];
  localparam logic signed [COORD_BITS-1:0] XY_MIN = COORD_MIN[COORD_BITS-1:0];
  localparam logic [RAD_W-1:0] RAD_MAX = '1;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 16;
  localparam int NEAR_SPAN = 1024;
  localparam int REPORT_LIMIT = 50;
  localparam int EXPECT_DEPTH = 64;

  typedef enum int {
    AIM_HEAD,
    AIM_NEAR_HEAD,
    AIM_NEXT,
    AIM_NEAR_NEXT,
    AIM_ON_RADIUS,
    AIM_MIDPOINT,
    AIM_ANYWHERE
  } aim_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [RAD_W-1:0]      r;
  } waypoint_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    status_t                      status;
  } target_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         item_valid = 1'b0;
  logic                         item_stall;
  logic                         operation = 1'b0;
  logic signed [COORD_BITS-1:0] x = '0;
  logic signed [COORD_BITS-1:0] y = '0;
  logic        [RAD_W-1:0]      radius = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [COORD_BITS-1:0] target_x;
  logic signed [COORD_BITS-1:0] target_y;
  logic        [1:0]            status;

  waypoint_t wp_ring [MAX_WAYPOINTS];
  int        wp_head = 0;
  int        wp_count = 0;
  target_t   expected_targets [EXPECT_DEPTH];
  int        expect_wr = 0;
  int        expect_rd = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;
  int targets_checked = 0;
  int rotations = 0;
  int drops = 0;

  waypoint_ring_follower_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .x            (x),
    .y            (y),
    .radius       (radius),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .target_x     (target_x),
    .target_y     (target_y),
    .status       (status)
  );

  always #5 clk = ~clk;

  function automatic longint dist_sq(input waypoint_t w, input longint px, input longint py);
    longint dx;
    longint dy;
    dx = longint'($signed(w.x)) - px;
    dy = longint'($signed(w.y)) - py;
    return dx * dx + dy * dy;
  endfunction

  function automatic void rotate_ring();
    wp_ring[(wp_head + wp_count) % MAX_WAYPOINTS] = wp_ring[wp_head];
    wp_head = (wp_head + 1) % MAX_WAYPOINTS;
    rotations++;
  endfunction

  // Applies one accepted transaction to the ring and queues the head it leaves behind.
  function automatic void predict_target(input op_t op,
                                         input logic signed [COORD_BITS-1:0] px,
                                         input logic signed [COORD_BITS-1:0] py,
                                         input logic [RAD_W-1:0] r);
    target_t t;
    longint  cur;
    longint  nd;
    longint  rr;
    t.status = STATUS_OK;
    if (op == OP_APPEND) begin
      if (wp_count >= MAX_WAYPOINTS) begin
        t.status = STATUS_FULL;
        drops++;
      end else begin
        wp_ring[(wp_head + wp_count) % MAX_WAYPOINTS] = '{px, py, r};
        wp_count++;
      end
    end else if (wp_count == 0) begin
      t.status = STATUS_EMPTY;
    end else begin
      cur = dist_sq(wp_ring[wp_head], longint'(px), longint'(py));
      if (wp_count > NEAR_MIN_COUNT) begin
        nd = dist_sq(wp_ring[(wp_head + 1) % MAX_WAYPOINTS], longint'(px), longint'(py));
        if (nd < cur) begin
          rotate_ring();
          cur = nd;
        end
      end
      rr = longint'(wp_ring[wp_head].r);
      if (cur < rr * rr) begin
        rotate_ring();
      end
    end
    if (wp_count == 0) begin
      t.x = '0;
      t.y = '0;
    end else begin
      t.x = wp_ring[wp_head].x;
      t.y = wp_ring[wp_head].y;
    end
    expected_targets[expect_wr % EXPECT_DEPTH] = t;
    expect_wr++;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    logic [31:0] raw;
    raw = $urandom();
    return raw[COORD_BITS-1:0];
  endfunction

  function automatic logic [RAD_W-1:0] rand_radius();
    logic [31:0] raw;
    raw = $urandom();
    return raw[RAD_W-1:0];
  endfunction

  function automatic logic [RAD_W-1:0] waypoint_radius();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return RAD_MAX;
      default: return RAD_W'($urandom_range(65535, 0));
    endcase
  endfunction

  function automatic longint jitter();
    return longint'($urandom_range(2 * NEAR_SPAN, 0)) - NEAR_SPAN;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end else if (v < COORD_MIN) begin
      v = COORD_MIN;
    end
    return v[COORD_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    mismatches++;
  endtask

  // Starts and ends at a falling edge; the payload holds until the transaction is taken.
  task automatic send_item(input op_t op,
                           input logic signed [COORD_BITS-1:0] px,
                           input logic signed [COORD_BITS-1:0] py,
                           input logic [RAD_W-1:0] r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    x <= px;
    y <= py;
    radius <= r;
    do @(posedge clk); while (item_stall);
    predict_target(op, px, py, r);
    items_sent++;
    @(negedge clk);
  endtask

  // Picks a query position relative to the current head and next waypoint, or a random one.
  task automatic send_query(input aim_t aim);
    waypoint_t h;
    waypoint_t n;
    longint    qx;
    longint    qy;
    if (wp_count == 0) begin
      aim = AIM_ANYWHERE;
    end
    h = wp_ring[wp_head];
    n = (wp_count > 1) ? wp_ring[(wp_head + 1) % MAX_WAYPOINTS] : h;
    case (aim)
      AIM_HEAD: begin
        qx = $signed(h.x);
        qy = $signed(h.y);
      end
      AIM_NEAR_HEAD: begin
        qx = longint'($signed(h.x)) + jitter();
        qy = longint'($signed(h.y)) + jitter();
      end
      AIM_NEXT: begin
        qx = $signed(n.x);
        qy = $signed(n.y);
      end
      AIM_NEAR_NEXT: begin
        qx = longint'($signed(n.x)) + jitter();
        qy = longint'($signed(n.y)) + jitter();
      end
      AIM_ON_RADIUS: begin
        qx = longint'($signed(h.x)) + longint'(h.r);
        if (qx > COORD_MAX) begin
          qx = longint'($signed(h.x)) - longint'(h.r);
        end
        qy = $signed(h.y);
      end
      AIM_MIDPOINT: begin
        qx = (longint'($signed(h.x)) + longint'($signed(n.x))) >>> 1;
        qy = (longint'($signed(h.y)) + longint'($signed(n.y))) >>> 1;
      end
      default: begin
        qx = rand_coord();
        qy = rand_coord();
      end
    endcase
    send_item(OP_QUERY, clamp_coord(qx), clamp_coord(qy), rand_radius());
  endtask

  task automatic send_random_item();
    if ($urandom_range(4, 0) == 0) begin
      send_item(OP_APPEND, rand_coord(), rand_coord(), rand_radius());
    end else begin
      send_query(aim_t'($urandom_range(AIM_ANYWHERE, AIM_HEAD)));
    end
  endtask

  task automatic test_empty_and_single();
    send_item(OP_QUERY, XY_MIN, XY_MAX, RAD_MAX);
    send_item(OP_APPEND, XY_MAX, XY_MIN, RAD_MAX);
    send_query(AIM_HEAD);
    send_item(OP_QUERY, XY_MIN, XY_MAX, '0);
  endtask

  task automatic test_two_waypoints();
    send_item(OP_APPEND, -24'sd25600, 24'sd12800, 23'd256);
    send_item(OP_QUERY, XY_MAX, XY_MIN, '0);
    send_query(AIM_ON_RADIUS);
    send_query(AIM_HEAD);
  endtask

  task automatic test_fill_and_overflow();
    repeat (MAX_WAYPOINTS - 2) begin
      send_item(OP_APPEND, rand_coord(), rand_coord(), waypoint_radius());
    end
    send_item(OP_APPEND, XY_MIN, XY_MAX, '0);
    send_query(AIM_NEXT);
    send_query(AIM_MIDPOINT);
  endtask

  task automatic test_random_mix(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) begin
      send_random_item();
    end
  endtask

  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (24) begin
      send_random_item();
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    target_t want;
    if (!rst && result_valid && !result_stall) begin
      targets_checked++;
      if (expect_rd == expect_wr) begin
        report_mismatch($sformatf("result (%0d, %0d) status %0d with nothing pending",
                                  target_x, target_y, status));
      end else begin
        want = expected_targets[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (target_x !== want.x) begin
          report_mismatch($sformatf("target_x %0d, expected %0d", target_x, want.x));
        end
        if (target_y !== want.y) begin
          report_mismatch($sformatf("target_y %0d, expected %0d", target_y, want.y));
        end
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_and_single();
    test_two_waypoints();
    test_fill_and_overflow();
    test_random_mix(200, 30, 69);
    test_random_mix(200, 69, 30);
    test_receiver_hold();
    test_random_mix(200, 0, 0);
    item_valid <= 1'b0;
    while (expect_wr != expect_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results, with %0d mismatches.",
             items_sent, targets_checked, mismatches);
    $display("The ring rotated %0d times and %0d appends were dropped on a full list.",
             rotations, drops);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expect_wr - expect_rd);
    $display("Some tests failed");
    $finish;
  end

endmodule
